### sv/ech_pkg.sv
// ----------------------------------------------------------------------------
// ech_pkg
// shared types and constants for the stereo multitap echo core
// ----------------------------------------------------------------------------
package ech_pkg;

    localparam int HIST_AW    = 16;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int CNT_W      = HIST_AW + 1;
    localparam int MAX_TAPS   = 8;
    localparam int TAP_W      = 4;
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 19;
    localparam int GAIN_W     = 16;
    localparam int CFG_W      = 19;
    localparam int CFG_IDX_W  = 3;
    // running sum of up to nine tap spacings, eighths of a sample
    localparam int DSUM_W     = 23;
    localparam int K_W        = DSUM_W - 3;
    localparam int PROD_W     = GAIN_W + 1 + SAMPLE_W;
    localparam int TERM_W     = PROD_W - GAIN_W;
    localparam int ACC_W      = 21;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_L = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_R = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_L  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_R  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS    = 3'd4;

    localparam logic [DELAY_W-1:0] DELAY_RST = 19'd132300;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd32768;
    localparam logic [TAP_W-1:0]   TAPS_RST  = 4'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out;

    typedef struct packed {
        logic start;
        logic issue;
    } t_chan_ctrl;

endpackage

### sv/ech_ram.sv
// ----------------------------------------------------------------------------
// ech_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module ech_ram #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ech_chan.sv
// ----------------------------------------------------------------------------
// ech_chan
// one channel: history ram, tap address and gain power, multiply, accumulate
// ----------------------------------------------------------------------------
module ech_chan import ech_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_chan_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic [DELAY_W-1:0]         i_delay,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic [HIST_AW-1:0]         i_wp,
    input  logic [CNT_W-1:0]           i_count,
    output logic signed [SAMPLE_W-1:0] o_y
);

    logic [DSUM_W-1:0]          r_dsum;
    logic [GAIN_W-1:0]          r_pow;
    logic [GAIN_W-1:0]          r_pow_b;
    logic                       r_vb;
    logic                       r_vc;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    logic [DSUM_W-1:0]          w_ksum;
    logic [K_W-1:0]             w_k;
    logic                       w_tap_ok;
    logic [HIST_AW-1:0]         w_raddr;
    logic [2*GAIN_W-1:0]        w_pow_mul;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_term;

    // k = ceil(i * delay / 8)
    assign w_ksum   = r_dsum + DSUM_W'(7);
    assign w_k      = w_ksum[DSUM_W-1:3];
    assign w_tap_ok = (w_k <= K_W'(i_count)) && (w_k[K_W-1:HIST_AW] == '0);
    assign w_raddr  = i_wp - w_k[HIST_AW-1:0];

    assign w_pow_mul = r_pow * i_gain;
    assign w_prod    = $signed({1'b0, r_pow_b}) * $signed(w_rdata);
    // arithmetic shift gives the floor of the q16 product
    assign w_term    = ACC_W'($signed(r_prod[PROD_W-1:GAIN_W]));

    ech_ram #(
        .AW (HIST_AW),
        .DW (SAMPLE_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.start),
        .i_waddr (i_wp),
        .i_wdata (i_x),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_vb <= i_ctrl.issue && w_tap_ok;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_dsum <= DSUM_W'(i_delay);
            r_pow  <= i_gain;
        end else if (i_ctrl.issue) begin
            r_dsum <= r_dsum + DSUM_W'(i_delay);
            r_pow  <= w_pow_mul[2*GAIN_W-1:GAIN_W];
        end
        r_pow_b <= r_pow;
        r_prod  <= w_prod;
        if (i_ctrl.start) begin
            r_acc <= ACC_W'(i_x);
        end else if (r_vc) begin
            r_acc <= r_acc + w_term;
        end
    end

    always_comb begin
        if (r_acc > ACC_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
            o_y = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (r_acc < -ACC_W'(signed'({1'b0, 1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
            o_y = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_y = r_acc[SAMPLE_W-1:0];
        end
    end

endmodule

### sv/stereo_multitap_echo_core.sv
// ----------------------------------------------------------------------------
// stereo_multitap_echo_core
// stereo feedforward multitap echo over a 64k-sample history per channel
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------
//  input     | in        | i_in_valid / o_in_ready   | i_in  (t_in)
//  output    | out       | o_out_valid / i_out_ready | o_out (t_out)
//  config    | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// each word makes one history write and then one history read per tap, with the
// tap count capped at 8, through the single read port of each channel ram,
// then a multiply and accumulate drain and a load of the result.
// reset clears control and pointers and restores config defaults; the history
// rams are not cleared, the sample count keeps unwritten entries from being used.
// a stalled output holds the finished word in the result stage; the next
// input word is taken as soon as the result register has it.
module stereo_multitap_echo_core import ech_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [DELAY_W-1:0]   r_delay_l;
    logic [DELAY_W-1:0]   r_delay_r;
    logic [GAIN_W-1:0]    r_gain_l;
    logic [GAIN_W-1:0]    r_gain_r;
    logic [TAP_W-1:0]     r_tap_count;
    logic [TAP_W-1:0]     r_tap;
    logic [TAP_W-1:0]     r_taps;
    logic                 r_drain;
    logic [HIST_AW-1:0]   r_wp;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    t_out                 r_out;

    logic                 w_accept;
    logic                 w_load;
    logic [TAP_W-1:0]     w_taps_eff;
    t_chan_ctrl           w_ctrl;
    logic signed [SAMPLE_W-1:0] w_y_l;
    logic signed [SAMPLE_W-1:0] w_y_r;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_taps_eff  = (r_tap_count > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : r_tap_count;
    assign w_ctrl.start = w_accept;
    assign w_ctrl.issue = (r_state == S_ISSUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_l   <= DELAY_RST;
            r_delay_r   <= DELAY_RST;
            r_gain_l    <= GAIN_RST;
            r_gain_r    <= GAIN_RST;
            r_tap_count <= TAPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELAY_L: r_delay_l   <= i_cfg_data[DELAY_W-1:0];
                REG_DELAY_R: r_delay_r   <= i_cfg_data[DELAY_W-1:0];
                REG_GAIN_L:  r_gain_l    <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_R:  r_gain_r    <= i_cfg_data[GAIN_W-1:0];
                REG_TAPS:    r_tap_count <= i_cfg_data[TAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_taps_eff == '0) ? S_DRAIN : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_tap == r_taps) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_taps      <= '0;
            r_drain     <= 1'b0;
            r_wp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tap  <= TAP_W'(1);
                r_taps <= w_taps_eff;
            end else if (r_state == S_ISSUE) begin
                r_tap <= r_tap + TAP_W'(1);
            end
            r_drain <= (r_state == S_DRAIN) && !r_drain;
            if (w_load) begin
                r_wp        <= r_wp + HIST_AW'(1);
                r_out_valid <= 1'b1;
                if (r_count < CNT_W'(HIST_DEPTH)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.left_out  <= w_y_l;
            r_out.right_out <= w_y_r;
        end
    end

    ech_chan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_x     (i_in.left_in),
        .i_delay (r_delay_l),
        .i_gain  (r_gain_l),
        .i_wp    (r_wp),
        .i_count (r_count),
        .o_y     (w_y_l)
    );

    ech_chan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_x     (i_in.right_in),
        .i_delay (r_delay_r),
        .i_gain  (r_gain_r),
        .i_wp    (r_wp),
        .i_count (r_count),
        .o_y     (w_y_r)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_tap != '0) && (r_tap <= r_taps))
        else $error("tap index outside the active tap range");

    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_wp == $past(r_wp) + HIST_AW'(1)))
        else $error("write pointer did not advance by one on result load");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HIST_DEPTH))
        else $error("sample count beyond history depth");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready && !w_load)
        else $error("new word taken or result loaded right after accept");
`endif

endmodule
